>>> rtl/core/irn_pkg.sv
// shared types, constants and the microcode rom of the roman numeral converter
package irn_pkg;

    localparam int ValueW     = 12;
    localparam int SymW       = 7;
    localparam int DigitW     = 4;
    localparam int NumDigits  = 4;
    localparam int PosW       = 2;
    localparam int LeftW      = 3;
    localparam int AddrW      = 4;
    localparam int RomanLimit = 3999;
    // floor(t / 10) == (t * 6554) >> 16 for every 12-bit t
    localparam int RecipMul   = 6554;
    localparam int RecipShift = 16;
    localparam int ProdW      = ValueW + 13;
    localparam int QuotW      = ProdW - RecipShift;

    typedef logic [2:0]       t_op;
    typedef logic [1:0]       t_sel;
    typedef logic [2:0]       t_cond;
    typedef logic [AddrW-1:0] t_addr;
    typedef logic [LeftW-1:0] t_left;
    typedef logic [DigitW-1:0] t_digit;

    // micro operations
    localparam t_op OP_LOAD     = 3'd0;
    localparam t_op OP_SPLIT    = 3'd1;
    localparam t_op OP_CHECK    = 3'd2;
    localparam t_op OP_ERR      = 3'd3;
    localparam t_op OP_DISPATCH = 3'd4;
    localparam t_op OP_NEXT     = 3'd5;
    localparam t_op OP_EMIT     = 3'd6;
    localparam t_op OP_EMIT_END = 3'd7;

    // letter select relative to the digit position
    localparam t_sel SEL_UNIT = 2'd0;
    localparam t_sel SEL_FIVE = 2'd1;
    localparam t_sel SEL_TEN  = 2'd2;

    // jump conditions
    localparam t_cond C_ALWAYS     = 3'd0;
    localparam t_cond C_SPLIT_DONE = 3'd1;
    localparam t_cond C_RANGE_ERR  = 3'd2;
    localparam t_cond C_POS_ZERO   = 3'd3;
    localparam t_cond C_LEFT_TWO   = 3'd4;

    // microcode addresses
    localparam t_addr A_WAIT      = 4'd0;
    localparam t_addr A_SPLIT     = 4'd1;
    localparam t_addr A_CHECK     = 4'd2;
    localparam t_addr A_ERR       = 4'd3;
    localparam t_addr A_DISPATCH  = 4'd4;
    localparam t_addr A_SKIP      = 4'd5;
    localparam t_addr A_UNIT_LOOP = 4'd6;
    localparam t_addr A_UNIT_END  = 4'd7;
    localparam t_addr A_FOUR      = 4'd8;
    localparam t_addr A_FIVE_END  = 4'd9;
    localparam t_addr A_FIVE_HEAD = 4'd10;
    localparam t_addr A_NINE      = 4'd11;
    localparam t_addr A_TEN_END   = 4'd12;

    typedef struct packed {
        t_op   op;
        t_sel  sel;
        t_cond cond;
        t_addr tgt_t;
        t_addr tgt_f;
    } t_uword;

    typedef struct packed {
        t_addr entry;
        t_left left;
    } t_disp;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic   accept;
        logic   out_free;
        logic   split_done;
        logic   range_err;
        logic   pos_zero;
        logic   left_two;
        t_digit digit;
    } t_stat;

    // control from the sequencer to the datapath
    typedef struct packed {
        t_op   op;
        t_sel  sel;
        logic  fire;
        t_left left_init;
    } t_ctrl;

    // microcode program
    function automatic t_uword ucode(input t_addr a);
        t_uword w;
        unique case (a)
            A_WAIT:      w = '{OP_LOAD,     SEL_UNIT, C_ALWAYS,     A_SPLIT,     A_SPLIT};
            A_SPLIT:     w = '{OP_SPLIT,    SEL_UNIT, C_SPLIT_DONE, A_CHECK,     A_SPLIT};
            A_CHECK:     w = '{OP_CHECK,    SEL_UNIT, C_RANGE_ERR,  A_ERR,       A_DISPATCH};
            A_ERR:       w = '{OP_ERR,      SEL_UNIT, C_ALWAYS,     A_WAIT,      A_WAIT};
            A_DISPATCH:  w = '{OP_DISPATCH, SEL_UNIT, C_ALWAYS,     A_SKIP,      A_SKIP};
            A_SKIP:      w = '{OP_NEXT,     SEL_UNIT, C_POS_ZERO,   A_WAIT,      A_DISPATCH};
            A_UNIT_LOOP: w = '{OP_EMIT,     SEL_UNIT, C_LEFT_TWO,   A_UNIT_END,  A_UNIT_LOOP};
            A_UNIT_END:  w = '{OP_EMIT_END, SEL_UNIT, C_POS_ZERO,   A_WAIT,      A_DISPATCH};
            A_FOUR:      w = '{OP_EMIT,     SEL_UNIT, C_ALWAYS,     A_FIVE_END,  A_FIVE_END};
            A_FIVE_END:  w = '{OP_EMIT_END, SEL_FIVE, C_POS_ZERO,   A_WAIT,      A_DISPATCH};
            A_FIVE_HEAD: w = '{OP_EMIT,     SEL_FIVE, C_LEFT_TWO,   A_UNIT_END,  A_UNIT_LOOP};
            A_NINE:      w = '{OP_EMIT,     SEL_UNIT, C_ALWAYS,     A_TEN_END,   A_TEN_END};
            A_TEN_END:   w = '{OP_EMIT_END, SEL_TEN,  C_POS_ZERO,   A_WAIT,      A_DISPATCH};
            default:     w = '{OP_LOAD,     SEL_UNIT, C_ALWAYS,     A_SPLIT,     A_SPLIT};
        endcase
        return w;
    endfunction

    // digit dispatch: routine entry and unit count for the loop
    function automatic t_disp dispatch(input t_digit d);
        t_disp r;
        unique case (d)
            4'd1:    r = '{A_UNIT_END,  3'd0};
            4'd2:    r = '{A_UNIT_LOOP, 3'd2};
            4'd3:    r = '{A_UNIT_LOOP, 3'd3};
            4'd4:    r = '{A_FOUR,      3'd0};
            4'd5:    r = '{A_FIVE_END,  3'd0};
            4'd6:    r = '{A_FIVE_HEAD, 3'd2};
            4'd7:    r = '{A_FIVE_HEAD, 3'd3};
            4'd8:    r = '{A_FIVE_HEAD, 3'd4};
            4'd9:    r = '{A_NINE,      3'd0};
            default: r = '{A_SKIP,      3'd0};
        endcase
        return r;
    endfunction

    // roman letter table, index 2*position + select
    function automatic logic [SymW-1:0] letter(input logic [2:0] idx);
        logic [SymW-1:0] s;
        unique case (idx)
            3'd0:    s = 7'h49;
            3'd1:    s = 7'h56;
            3'd2:    s = 7'h58;
            3'd3:    s = 7'h4C;
            3'd4:    s = 7'h43;
            3'd5:    s = 7'h44;
            3'd6:    s = 7'h4D;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/irn_in_if.sv
// request channel carrying the value to convert
interface irn_in_if import irn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/core/irn_out_if.sv
// result channel carrying one roman letter per transfer
interface irn_out_if import irn_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SymW-1:0] symbol;
    logic            last;
    logic            out_of_range;

    modport source (output valid, output symbol, output last, output out_of_range, input ready);
    modport sink   (input valid, input symbol, input last, input out_of_range, output ready);
endinterface

>>> rtl/core/integer_to_roman_numeral.sv
// integer to roman numeral converter, top level
//
// i_req takes one 12-bit unsigned value per request; o_res returns its roman
// numeral as ASCII letters (I V X L C D M), thousands first, one letter per
// transfer, with last set on the final letter. A value of 0 gives no letters.
// A value above 3999 gives a single result with symbol 0, last 1 and
// out_of_range 1.
// A microcoded sequencer runs each request: a load step takes the value,
// split steps divide it into its four decimal digits (one multiply by a
// reciprocal of ten per digit), a range check step follows, then for each
// decimal digit a dispatch step is followed by its letter steps, each emitting
// one letter (a zero digit takes a skip step in place of letters); a value
// above 3999 goes from the check to an error step.
// i_req.ready is high only while the sequencer waits for a value, which it
// does even while the final letter still sits in the output register.
// A stall on o_res holds the letter register and freezes the sequencer at its
// next letter.
// Reset clears the sequencer, the output valid and the digit store.
module integer_to_roman_numeral import irn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    irn_in_if.sink          i_req,
    irn_out_if.source       o_res
);

    t_stat stat;
    t_ctrl ctrl;

    logic [ValueW-1:0] r_val;
    logic [ValueW-1:0] r_t;
    logic [PosW-1:0]   r_cnt;
    t_digit            r_digits [NumDigits];
    logic [PosW-1:0]   r_pos;
    t_left             r_left;
    logic              r_out_valid;
    logic [SymW-1:0]   r_sym;
    logic              r_last;
    logic              r_oor;

    logic [ProdW-1:0]  prod;
    logic [ValueW-1:0] quot;
    logic [ValueW-1:0] rem_full;
    logic              lower_zero;
    logic [2:0]        letter_idx;
    logic              out_free;

    irn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // divide by ten through the reciprocal
    always_comb begin
        prod     = ProdW'(r_t) * ProdW'(RecipMul);
        quot     = ValueW'(prod[ProdW-1:RecipShift]);
        rem_full = r_t - ValueW'(quot * ValueW'(10));
    end

    // all lower digits zero marks the final letter of a digit as the last
    always_comb begin
        unique case (r_pos)
            2'd0:    lower_zero = 1'b1;
            2'd1:    lower_zero = (r_digits[0] == '0);
            2'd2:    lower_zero = (r_digits[0] == '0) && (r_digits[1] == '0);
            default: lower_zero = (r_digits[0] == '0) && (r_digits[1] == '0) &&
                                  (r_digits[2] == '0);
        endcase
        letter_idx = {r_pos, 1'b0} + {1'b0, ctrl.sel};
    end

    // status to the sequencer
    assign out_free = !r_out_valid || o_res.ready;
    always_comb begin
        stat.accept     = i_req.valid;
        stat.out_free   = out_free;
        stat.split_done = (r_cnt == PosW'(NumDigits - 1));
        stat.range_err  = (r_val > ValueW'(RomanLimit));
        stat.pos_zero   = (r_pos == '0);
        stat.left_two   = (r_left == LeftW'(2));
        stat.digit      = r_digits[r_pos];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pos  <= '0;
            r_left <= '0;
            for (int i = 0; i < NumDigits; i++) begin
                r_digits[i] <= '0;
            end
        end else if (ctrl.fire) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    r_val <= i_req.value;
                    r_t   <= i_req.value;
                    r_cnt <= '0;
                end
                OP_SPLIT: begin
                    r_digits[r_cnt] <= rem_full[DigitW-1:0];
                    r_t             <= quot;
                    r_cnt           <= r_cnt + 1'b1;
                end
                OP_CHECK: begin
                    r_pos <= PosW'(NumDigits - 1);
                end
                OP_DISPATCH: begin
                    r_left <= ctrl.left_init;
                end
                OP_NEXT: begin
                    r_pos <= r_pos - 1'b1;
                end
                OP_EMIT: begin
                    r_left <= r_left - 1'b1;
                end
                OP_EMIT_END: begin
                    r_pos  <= r_pos - 1'b1;
                    r_left <= '0;
                end
                default: begin
                    r_left <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fire && (ctrl.op == OP_EMIT || ctrl.op == OP_EMIT_END ||
                                   ctrl.op == OP_ERR)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            unique case (ctrl.op)
                OP_ERR: begin
                    r_sym  <= '0;
                    r_last <= 1'b1;
                    r_oor  <= 1'b1;
                end
                OP_EMIT: begin
                    r_sym  <= letter(letter_idx);
                    r_last <= 1'b0;
                    r_oor  <= 1'b0;
                end
                OP_EMIT_END: begin
                    r_sym  <= letter(letter_idx);
                    r_last <= lower_zero;
                    r_oor  <= 1'b0;
                end
                default: begin
                    r_sym  <= r_sym;
                end
            endcase
        end
    end

    assign i_req.ready        = (ctrl.op == OP_LOAD);
    assign o_res.valid        = r_out_valid;
    assign o_res.symbol       = r_sym;
    assign o_res.last         = r_last;
    assign o_res.out_of_range = r_oor;

endmodule

>>> rtl/core/irn_seq.sv
// microcode sequencer: step counter, control rom and jump logic
module irn_seq import irn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_addr  r_step;
    t_addr  n_step;
    t_uword w;
    t_disp  disp;
    logic   cond;
    logic   fire;

    // decode current control word
    always_comb begin
        w    = ucode(r_step);
        disp = dispatch(i_stat.digit);
        unique case (w.cond)
            C_ALWAYS:     cond = 1'b1;
            C_SPLIT_DONE: cond = i_stat.split_done;
            C_RANGE_ERR:  cond = i_stat.range_err;
            C_POS_ZERO:   cond = i_stat.pos_zero;
            C_LEFT_TWO:   cond = i_stat.left_two;
            default:      cond = 1'b1;
        endcase
        unique case (w.op)
            OP_LOAD:                     fire = i_stat.accept;
            OP_ERR, OP_EMIT, OP_EMIT_END: fire = i_stat.out_free;
            default:                     fire = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (!fire) begin
            n_step = r_step;
        end else if (w.op == OP_DISPATCH) begin
            n_step = disp.entry;
        end else begin
            n_step = cond ? w.tgt_t : w.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= A_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = '{op: w.op, sel: w.sel, fire: fire, left_init: disp.left};

endmodule

>>> rtl/core/irn_chk.sv
// port checker for the roman numeral converter and its bind
module irn_chk import irn_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [SymW-1:0] i_symbol,
    input logic            i_last,
    input logic            i_out_of_range
);

    // an error result is a lone letterless final result
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |-> (i_symbol == '0) && i_last)
        else $error("error result without zero symbol and last");

    // a normal result is always a roman letter
    a_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_of_range |->
            (i_symbol == 7'h49) || (i_symbol == 7'h56) || (i_symbol == 7'h58) ||
            (i_symbol == 7'h4C) || (i_symbol == 7'h43) || (i_symbol == 7'h44) ||
            (i_symbol == 7'h4D))
        else $error("result symbol is not a roman letter");

    // a taken request keeps the converter busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one just started");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_symbol) && $stable(i_last) && $stable(i_out_of_range))
        else $error("stalled result changed");

endmodule

bind integer_to_roman_numeral irn_chk u_irn_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_symbol       (o_res.symbol),
    .i_last         (o_res.last),
    .i_out_of_range (o_res.out_of_range)
);
